/* rtl/core/sliding_window_duty_cycle_limiter_unit_defines.svh */
// Assertion macros used by the duty-cycle limiter RTL.
`ifndef SLIDING_WINDOW_DUTY_CYCLE_LIMITER_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_DUTY_CYCLE_LIMITER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SWDCL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SWDCL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/swdcl_pkg.sv */
// Types and constants of the sliding-window duty-cycle limiter.
package swdcl_pkg;

	// History storage.
	localparam int HIST_DEPTH = 64;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
	localparam int WIDX_W     = HIST_AW + 1;

	// Field and register widths.
	localparam int WIN_W      = 27;
	localparam int LIM_W      = 17;
	localparam int NOW_W      = 32;
	localparam int AIR_W      = 16;
	localparam int SUM_W      = 32;
	localparam int FRAC_W     = 16;
	localparam int PROD_W     = WIN_W + LIM_W;
	localparam int LHS_W      = SUM_W + 1 + FRAC_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 27;

	// Register reset values and the Q1.16 value of one.
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(3600000);
	localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(6554);
	localparam logic [LIM_W-1:0] LIM_ONE   = LIM_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW = 1'b0,
		CFG_LIMIT  = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_CHECK  = 1'b0,
		OP_RECORD = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EV_RD,
		ST_EV_CMP,
		ST_EV_SUB,
		ST_SUM,
		ST_DECIDE,
		ST_DONE
	} state_t;

endpackage

/* rtl/core/sliding_window_duty_cycle_limiter_unit.sv */
// Sequence: after the input transfer, expired records are evicted oldest first by read,
// compare and subtract steps; a kept record ends the walk. Sum and decide steps follow.
// Items are taken one at a time, as the shared 33-bit add/subtract unit walks the history
// one record per eviction step. The next item may be taken while a result waits.
// Reset (arst_n, asynchronous) empties the history, clears the airtime sum and
// loads the window and limit registers with their defaults; no clearing pass.
`include "sliding_window_duty_cycle_limiter_unit_defines.svh"

module sliding_window_duty_cycle_limiter_unit
	import swdcl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Input item channel.
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  opcode,
	input  logic [NOW_W-1:0]      now_ms,
	input  logic [AIR_W-1:0]      airtime_ms,
	// Result channel.
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  allowed,
	output logic [SUM_W-1:0]      used_airtime_ms,
	output logic                  history_full
);

	state_t               state_q, state_d;
	logic [WIN_W-1:0]     window_q;
	logic [LIM_W-1:0]     limit_q;
	logic [HIST_AW-1:0]   oldest_q;
	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 out_valid_q;

	op_t                  op_q;
	logic [NOW_W-1:0]     now_q;
	logic [AIR_W-1:0]     air_q;
	logic [NOW_W-1:0]     rd_start_q;
	logic [AIR_W-1:0]     rd_air_q;
	logic [SUM_W:0]       sa_q;
	logic [PROD_W-1:0]    prod_q;
	logic                 allowed_res_q;
	logic                 full_res_q;
	logic                 allowed_q;
	logic [SUM_W-1:0]     used_q;
	logic                 hist_full_q;

	logic [NOW_W-1:0]     start_mem [HIST_DEPTH];
	logic [AIR_W-1:0]     air_mem [HIST_DEPTH];

	logic                 in_xfer;
	logic                 out_free;
	logic                 load_out;
	logic                 mem_rd;
	logic                 mem_wr;
	logic                 hist_full;
	logic                 evict_hit;
	logic                 alu_sub;
	logic [SUM_W-1:0]     alu_a;
	logic [SUM_W-1:0]     alu_b;
	logic [SUM_W:0]       alu_res;
	logic [WIDX_W-1:0]    wr_sum;
	logic [HIST_AW-1:0]   wr_idx;
	logic [HIST_AW-1:0]   oldest_inc;
	logic [LHS_W-1:0]     lhs;
	cfg_reg_t             cfg_reg;

	// Configuration is always taken.
	assign cfg_ready = 1'b1;
	assign cfg_reg   = cfg_reg_t'(cfg_index);

	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign hist_full = (count_q == CNT_W'(HIST_DEPTH));

	// Shared add/subtract unit.
	assign alu_res   = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
	                           : ({1'b0, alu_a} + {1'b0, alu_b});
	assign evict_hit = (alu_res < {1'b0, now_q});

	// Append position and oldest-pointer increment, wrapping at the depth.
	assign wr_sum     = WIDX_W'(oldest_q) + WIDX_W'(count_q);
	assign wr_idx     = (wr_sum >= WIDX_W'(HIST_DEPTH)) ?
	                    HIST_AW'(wr_sum - WIDX_W'(HIST_DEPTH)) : HIST_AW'(wr_sum);
	assign oldest_inc = (oldest_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : oldest_q + 1'b1;

	// Projected use in Q33.16, on the scale of the Q1.16 limit times the window.
	assign lhs = {sa_q, {FRAC_W{1'b0}}};

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (count_q == '0) ? ST_SUM : ST_EV_RD;
				end
			end
			ST_EV_RD:  state_d = ST_EV_CMP;
			ST_EV_CMP: state_d = evict_hit ? ST_EV_SUB : ST_SUM;
			ST_EV_SUB: state_d = (count_q == CNT_W'(1)) ? ST_SUM : ST_EV_RD;
			ST_SUM:    state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// Control outputs and operand selection of the shared unit.
	always_comb begin
		in_stall = 1'b1;
		mem_rd   = 1'b0;
		mem_wr   = 1'b0;
		load_out = 1'b0;
		alu_sub  = 1'b0;
		alu_a    = sum_q;
		alu_b    = SUM_W'(air_q);
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_EV_RD:  mem_rd = 1'b1;
			ST_EV_CMP: begin
				alu_a = rd_start_q;
				alu_b = SUM_W'(window_q);
			end
			ST_EV_SUB: begin
				alu_sub = 1'b1;
				alu_b   = SUM_W'(rd_air_q);
			end
			ST_SUM:    ;
			ST_DECIDE: mem_wr = (op_q == OP_RECORD) && !hist_full;
			ST_DONE:   load_out = out_free;
			default:   ;
		endcase
	end

	// Control state: sequencer, configuration, history pointers and sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= WIN_RESET;
			limit_q     <= LIM_RESET;
			oldest_q    <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg)
					CFG_WINDOW: window_q <= cfg_data[WIN_W-1:0];
					CFG_LIMIT:  limit_q  <= (cfg_data[LIM_W-1:0] > LIM_ONE) ?
					                        LIM_ONE : cfg_data[LIM_W-1:0];
				endcase
			end
			// Evict the oldest record, flooring the sum at zero.
			if (state_q == ST_EV_SUB) begin
				sum_q    <= alu_res[SUM_W] ? '0 : alu_res[SUM_W-1:0];
				oldest_q <= oldest_inc;
				count_q  <= count_q - 1'b1;
			end
			// Append with a saturating sum.
			if (mem_wr) begin
				sum_q   <= sa_q[SUM_W] ? '1 : sa_q[SUM_W-1:0];
				count_q <= count_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item payload, intermediate values and result fields.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q  <= op_t'(opcode);
			now_q <= now_ms;
			air_q <= airtime_ms;
		end
		if (state_q == ST_SUM) begin
			sa_q   <= alu_res;
			prod_q <= PROD_W'(limit_q) * PROD_W'(window_q);
		end
		if (state_q == ST_DECIDE) begin
			allowed_res_q <= (window_q == '0) || (lhs <= LHS_W'(prod_q));
			full_res_q    <= (op_q == OP_RECORD) && hist_full;
		end
		if (load_out) begin
			allowed_q   <= allowed_res_q;
			used_q      <= (window_q == '0) ? '0 : sum_q;
			hist_full_q <= full_res_q;
		end
	end

	// History memory: one read port, one write port, registered read data.
	always_ff @(posedge clk) begin
		if (mem_rd) begin
			rd_start_q <= start_mem[oldest_q];
			rd_air_q   <= air_mem[oldest_q];
		end
		if (mem_wr) begin
			start_mem[wr_idx] <= now_q;
			air_mem[wr_idx]   <= air_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign allowed         = allowed_q;
	assign used_airtime_ms = used_q;
	assign history_full    = hist_full_q;

	// Checks on the sequencer and the history bookkeeping.
	`SWDCL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(HIST_DEPTH), "record count above depth")
	`SWDCL_ASSERT_NEXT(a_evict_dec, state_q == ST_EV_SUB, count_q == $past(count_q) - 1'b1, "eviction did not drop one record")
	`SWDCL_ASSERT_NEXT(a_append_inc, mem_wr, count_q == $past(count_q) + 1'b1, "append did not add one record")
	`SWDCL_ASSERT_NOW(a_zero_window_used, out_valid_q && (window_q == '0), used_q == '0, "nonzero use with zero window")

endmodule

/* tb/sv/sliding_window_duty_cycle_limiter_unit_test.sv */
// Self-checking testbench for the sliding-window duty-cycle limiter unit.
module sliding_window_duty_cycle_limiter_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import swdcl_pkg::*;

	typedef struct packed {
		op_t              op;
		logic [NOW_W-1:0] now;
		logic [AIR_W-1:0] air;
	} frame_req_t;

	typedef struct packed {
		logic             allowed;
		logic [SUM_W-1:0] used;
		logic             full;
	} duty_verdict_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  opcode = 1'b0;
	logic [NOW_W-1:0]      now_ms = '0;
	logic [AIR_W-1:0]      airtime_ms = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  allowed;
	logic [SUM_W-1:0]      used_airtime_ms;
	logic                  history_full;

	// Frames waiting to be sent and verdicts waiting to come back.
	frame_req_t    frames_to_send[$];
	duty_verdict_t verdicts_due[$];
	int            fail_count = 0;
	bit            in_took = 1'b0;
	bit            steady = 1'b0;
	logic [NOW_W-1:0] sim_now = '0;

	// Shadow copy of the registers and the transmission history.
	logic [WIN_W-1:0]   win_reg = WIN_RESET;
	logic [LIM_W-1:0]   lim_reg = LIM_RESET;
	logic [NOW_W-1:0]   rec_start [HIST_DEPTH];
	logic [AIR_W-1:0]   rec_air [HIST_DEPTH];
	logic [HIST_AW-1:0] rec_head = '0;
	logic [CNT_W-1:0]   rec_count = '0;
	logic [SUM_W-1:0]   air_sum = '0;

	sliding_window_duty_cycle_limiter_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.now_ms          (now_ms),
		.airtime_ms      (airtime_ms),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.allowed         (allowed),
		.used_airtime_ms (used_airtime_ms),
		.history_full    (history_full)
	);

	always #5 clk = ~clk;

	// Updates the shadow history for one frame and returns the verdict it earns.
	function automatic duty_verdict_t judge_airtime(input frame_req_t f);
		duty_verdict_t      v;
		logic [63:0]        lhs;
		logic [63:0]        rhs;
		logic [SUM_W:0]     sum_next;
		logic [HIST_AW-1:0] tail;
		// Retire records that started more than a window ago, oldest first only.
		while (rec_count != 0 &&
				({1'b0, rec_start[rec_head]} + (SUM_W+1)'(win_reg)) < {1'b0, f.now}) begin
			air_sum = (air_sum >= rec_air[rec_head]) ? air_sum - rec_air[rec_head] : '0;
			rec_head = rec_head + 1'b1;
			rec_count = rec_count - 1'b1;
		end
		// The decision sees the history before this frame is added.
		v.full = 1'b0;
		if (win_reg == '0) begin
			v.allowed = 1'b1;
		end else begin
			lhs = (64'(air_sum) + 64'(f.air)) << FRAC_W;
			rhs = 64'(lim_reg) * 64'(win_reg);
			v.allowed = (lhs <= rhs);
		end
		// A record frame is appended unless the history is already full.
		if (f.op == OP_RECORD) begin
			if (rec_count >= HIST_DEPTH) begin
				v.full = 1'b1;
			end else begin
				tail = rec_head + rec_count[HIST_AW-1:0];
				rec_start[tail] = f.now;
				rec_air[tail] = f.air;
				rec_count = rec_count + 1'b1;
				sum_next = (SUM_W+1)'(air_sum) + (SUM_W+1)'(f.air);
				air_sum = sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
			end
		end
		v.used = (win_reg == '0) ? '0 : air_sum;
		return v;
	endfunction

	task automatic check_field(input string field, input logic [SUM_W-1:0] want,
			input logic [SUM_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	// Result transfers are checked before the input transfer of the same edge is predicted.
	always @(posedge clk) begin : watch_ports
		duty_verdict_t due;
		frame_req_t    seen;
		in_took = 1'b0;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (verdicts_due.size() == 0) begin
					$error("result transfer with no verdict pending");
					fail_count++;
				end else begin
					due = verdicts_due[0];
					verdicts_due.delete(0);
					check_field("allowed", SUM_W'(due.allowed), SUM_W'(allowed));
					check_field("used_airtime_ms", due.used, used_airtime_ms);
					check_field("history_full", SUM_W'(due.full), SUM_W'(history_full));
				end
			end
			if (in_valid && !in_stall) begin
				seen.op = op_t'(opcode);
				seen.now = now_ms;
				seen.air = airtime_ms;
				verdicts_due.push_back(judge_airtime(seen));
				in_took = 1'b1;
			end
		end
	end

	// Presents frames with random gaps and stalls the result side at random.
	always @(negedge clk) begin : drive_ports
		frame_req_t nxt;
		if (arst_n && (!in_valid || in_took)) begin
			if (frames_to_send.size() != 0 && (steady || $urandom_range(99) >= 37)) begin
				nxt = frames_to_send[0];
				frames_to_send.delete(0);
				in_valid <= 1'b1;
				opcode <= nxt.op;
				now_ms <= nxt.now;
				airtime_ms <= nxt.air;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= !steady && ($urandom_range(99) < 37);
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_WINDOW) begin
			win_reg = data[WIN_W-1:0];
		end else begin
			lim_reg = (data[LIM_W-1:0] > LIM_ONE) ? LIM_ONE : data[LIM_W-1:0];
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic queue_frame(input op_t op, input logic [NOW_W-1:0] now,
			input logic [AIR_W-1:0] air);
		frames_to_send.push_back('{op, now, air});
		sim_now = now;
	endtask

	// Waits until every frame has been sent and every verdict has come back.
	task automatic drain();
		do @(posedge clk);
		while (frames_to_send.size() != 0 || in_valid || verdicts_due.size() != 0);
	endtask

	// Random traffic: mostly bursts at one instant and steps inside the window,
	// with some jumps past the window, steps back in time and arbitrary times.
	task automatic queue_traffic(input int count, input bit tight);
		logic [NOW_W-1:0] pace;
		logic [NOW_W-1:0] at;
		logic [AIR_W-1:0] air;
		int unsigned      roll;
		op_t              op;
		pace = tight ? NOW_W'(3) : NOW_W'(win_reg >> 3) + 1;
		at = sim_now;
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(99);
			if (roll < 30) begin
				at += $urandom_range(pace);
			end else if (roll < 38) begin
				at += NOW_W'(win_reg) + $urandom_range(3, 1);
			end else if (roll < 42) begin
				at -= $urandom_range(pace);
			end else if (roll < 45) begin
				at = $urandom;
			end
			op = ($urandom_range(3) != 0) ? OP_RECORD : OP_CHECK;
			roll = $urandom_range(9);
			if (roll == 0) begin
				air = '0;
			end else if (roll == 1) begin
				air = '1;
			end else if (roll < 5) begin
				air = AIR_W'($urandom_range(255));
			end else begin
				air = AIR_W'($urandom);
			end
			queue_frame(op, at, air);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Default registers: early time, both opcodes, field extremes and a
		// start time close enough to the top that start plus window needs 33 bits.
		@(posedge clk);
		queue_frame(OP_CHECK, 32'd0, 16'd0);
		queue_frame(OP_CHECK, 32'd0, 16'hFFFF);
		queue_frame(OP_RECORD, 32'd0, 16'hFFFF);
		queue_frame(OP_RECORD, 32'd10, 16'd1);
		queue_frame(OP_CHECK, 32'd3600000, 16'd0);
		queue_frame(OP_CHECK, 32'd3600001, 16'd0);
		queue_frame(OP_RECORD, 32'hFFFF_FF00, 16'd100);
		queue_frame(OP_CHECK, 32'hFFFF_FFFF, 16'd0);
		queue_frame(OP_CHECK, 32'd5, 16'd0);
		queue_frame(OP_RECORD, 32'hFFFF_FFFF, 16'h8000);
		drain();

		// Zero window: older records go, the same instant stays, always allowed.
		write_reg(CFG_WINDOW, '0);
		write_reg(CFG_LIMIT, '0);
		@(posedge clk);
		queue_frame(OP_CHECK, 32'hFFFF_FFFF, 16'd7);
		queue_frame(OP_RECORD, 32'hFFFF_FFFF, 16'd9);
		drain();

		// Widest window and an oversized limit that clamps to one.
		write_reg(CFG_WINDOW, '1);
		write_reg(CFG_LIMIT, '1);
		@(posedge clk);
		queue_frame(OP_CHECK, 32'd0, 16'hFFFF);
		queue_frame(OP_RECORD, 32'd1, 16'd0);
		drain();

		// One-millisecond window with a zero limit.
		write_reg(CFG_WINDOW, CFG_DATA_W'(1));
		write_reg(CFG_LIMIT, '0);
		@(posedge clk);
		queue_frame(OP_CHECK, 32'd1, 16'd0);
		queue_frame(OP_RECORD, 32'd3, 16'd1);
		queue_frame(OP_RECORD, 32'd3, 16'd0);
		queue_frame(OP_CHECK, 32'd5, 16'd2);
		drain();

		// Random phases, each under its own register setting.
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin
					write_reg(CFG_WINDOW, CFG_DATA_W'(86400000));
					write_reg(CFG_LIMIT, CFG_DATA_W'(LIM_ONE));
				end
				1: begin
					write_reg(CFG_WINDOW, CFG_DATA_W'($urandom_range(200, 1)));
					write_reg(CFG_LIMIT, CFG_DATA_W'($urandom_range(65536)));
				end
				2: begin
					write_reg(CFG_WINDOW, '0);
					write_reg(CFG_LIMIT, CFG_DATA_W'($urandom));
				end
				3: begin
					write_reg(CFG_WINDOW, CFG_DATA_W'(WIN_RESET));
					write_reg(CFG_LIMIT, CFG_DATA_W'(LIM_RESET));
				end
				4: begin
					write_reg(CFG_LIMIT, '0);
					write_reg(CFG_WINDOW, '1);
				end
				5: begin
					write_reg(CFG_WINDOW, CFG_DATA_W'($urandom));
					write_reg(CFG_LIMIT, CFG_DATA_W'($urandom_range(65536)));
				end
				6: begin
					write_reg(CFG_WINDOW, CFG_DATA_W'($urandom_range(100000, 1000)));
					write_reg(CFG_LIMIT, CFG_DATA_W'($urandom_range(65536)));
				end
				default: begin
					write_reg(CFG_WINDOW, CFG_DATA_W'($urandom_range(20, 1)));
					write_reg(CFG_LIMIT, CFG_DATA_W'(LIM_ONE));
				end
			endcase
			@(posedge clk);
			if (p == 1 || p == 5) begin
				sim_now = $urandom;
			end
			// One phase runs back to back with no gaps and no stalls.
			steady = (p == 3);
			queue_traffic(100, (p % 2) == 0);
			drain();
			steady = 1'b0;
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Hard limit on the run time.
	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/swdcl_pkg.sv
rtl/core/sliding_window_duty_cycle_limiter_unit.sv
tb/sv/sliding_window_duty_cycle_limiter_unit_test.sv
